[rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/udr_pkg.sv]
`default_nettype none
package udr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 32;

  localparam int ATAN_IDX_W = 5;
  localparam int TRIG_W     = 34;
  localparam int MUL_A_W    = 40;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int SAT_W      = 48;

  localparam logic signed [TRIG_W-1:0]  CORDIC_K = 34'sd652032874;
  localparam logic signed [MUL_B_W-1:0] INV_4PI  = 32'sd341782638;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd2;

  localparam logic signed [15:0] SPEED_GAIN_RST = 16'sd256;
  localparam logic signed [15:0] TURN_GAIN_RST  = 16'sd256;
  localparam logic signed [31:0] HEIGHT_RST     = 32'sd32768;
  localparam logic signed [31:0] X_POS_RST      = 32'sd131072;
  localparam logic signed [31:0] Y_POS_RST      = 32'sd0;

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  // Arctangent of 2^-i in units of 2*pi/2^32.
  function automatic logic signed [TRIG_W-1:0] atan_lookup(logic [ATAN_IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7fff_ffff);
    lo = SAT_W'($signed(32'h8000_0000));
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return $signed(32'h8000_0000);
    return v[31:0];
  endfunction

  // Round a Q4.30 value to Q2.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W:0]    s;
    logic signed [TRIG_W-16:0] r;
    s = (TRIG_W+1)'(v) + (TRIG_W+1)'(32768);
    r = $signed(s[TRIG_W:16]);
    if (r > (TRIG_W-15)'(Q14_ONE)) return Q14_ONE;
    if (r < -(TRIG_W-15)'(Q14_ONE)) return -Q14_ONE;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

[rtl/udr_mul.sv]
`default_nettype none
module udr_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [udr_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [udr_pkg::MUL_B_W-1:0] b_i,
  output logic signed [udr_pkg::MUL_P_W-1:0]      p_o
);

  logic signed [udr_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= udr_pkg::MUL_P_W'(a_i) * udr_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[rtl/udr_cordic.sv]
`default_nettype none
module udr_cordic #(
  parameter int STEPS = udr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [31:0]                       angle_i,
  output logic                                   done_o,
  output logic signed [udr_pkg::TRIG_W-1:0]      cos_o,
  output logic signed [udr_pkg::TRIG_W-1:0]      sin_o
);

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                              busy_q;
  logic                              done_q;
  logic [CNT_W-1:0]                  iter_q;
  logic [1:0]                        quad_q;
  logic signed [udr_pkg::TRIG_W-1:0] x_q, y_q, z_q;

  logic [31:0]                       rnd_angle;
  logic [1:0]                        quad;
  logic [31:0]                       resid;
  logic signed [udr_pkg::TRIG_W-1:0] x_sh, y_sh, atan_v;

  // Pick the nearest quadrant; the residue lies in [-pi/4, pi/4).
  assign rnd_angle = angle_i + 32'h2000_0000;
  assign quad      = rnd_angle[31:30];
  assign resid     = angle_i - {quad, 30'd0};

  assign x_sh   = x_q >>> iter_q;
  assign y_sh   = y_q >>> iter_q;
  assign atan_v = udr_pkg::atan_lookup(udr_pkg::ATAN_IDX_W'(iter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quad_q <= quad;
      x_q    <= udr_pkg::CORDIC_K;
      y_q    <= '0;
      z_q    <= udr_pkg::TRIG_W'($signed(resid));
    end else if (busy_q) begin
      if (!z_q[udr_pkg::TRIG_W-1]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_v;
      end
    end
  end

  // Rotate back by the quadrant.
  always_comb begin
    case (quad_q)
      QUAD_0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      QUAD_1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      QUAD_2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      QUAD_3: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
      default: begin
        cos_o = x_q;
        sin_o = y_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

[rtl/unicycle_dead_reckoning_step.sv]
// A request is taken only while the sequencer is idle, and each one runs to its result before the
// next is taken; the CORDIC unit runs twice per request, one rotation per cycle, and a single
// multiplier serves all eight products.
// A finished result waits in the output register while the next request is taken.
// Reset: x = 2.0 m, y = 0, heading = 0, gains 1.0, height 0.5 m, no result pending.
`default_nettype none
`include "assert_macros.svh"
module unicycle_dead_reckoning_step #(
  parameter int CORDIC_STEPS = udr_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = udr_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [15:0]              forward_axis_i,
  input  wire logic signed [15:0]              turn_axis_i,
  input  wire logic [15:0]                     step_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [31:0]                   pos_x_o,
  output logic signed [31:0]                   pos_y_o,
  output logic signed [31:0]                   pos_z_o,
  output logic signed [15:0]                   quat_z_o,
  output logic signed [15:0]                   quat_w_o,
  output logic signed [31:0]                   vel_x_o,
  output logic signed [31:0]                   vel_y_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [udr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);

  localparam int DELTA_SH = 48 - ANGLE_BITS;
  localparam int MA = udr_pkg::MUL_A_W;
  localparam int MB = udr_pkg::MUL_B_W;
  localparam int TW = udr_pkg::TRIG_W;
  localparam int SW = udr_pkg::SAT_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_M0   = 15'h0002,
    S_M1   = 15'h0004,
    S_M2   = 15'h0008,
    S_M3   = 15'h0010,
    S_M4   = 15'h0020,
    S_CH   = 15'h0040,
    S_CHW  = 15'h0080,
    S_CF   = 15'h0100,
    S_CFW  = 15'h0200,
    S_V0   = 15'h0400,
    S_V1   = 15'h0800,
    S_V2   = 15'h1000,
    S_P0   = 15'h2000,
    S_P1   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0]           fwd_q, trn_q;
  logic [15:0]                  dt_q;
  logic signed [15:0]           speed_gain_q, turn_gain_q;
  logic signed [31:0]           height_q;
  logic signed [25:0]           speed_q;
  logic [ANGLE_BITS-1:0]        heading_q;
  logic signed [31:0]           x_q, y_q, vx_q, vy_q;
  logic signed [TW-1:0]         fc_q, fs_q;
  logic signed [15:0]           qz_q, qw_q;

  logic                         out_valid_q;
  logic signed [31:0]           pos_x_q, pos_y_q, pos_z_q, vel_x_q, vel_y_q;
  logic signed [15:0]           quat_z_q, quat_w_q;

  logic signed [MA-1:0]         mul_a;
  logic signed [MB-1:0]         mul_b;
  logic signed [udr_pkg::MUL_P_W-1:0] mul_p;
  logic signed [udr_pkg::MUL_P_W-1:0] delta_full;
  logic signed [MB-1:0]         dt_ext;

  logic                         cordic_start;
  logic                         cordic_done;
  logic [31:0]                  cordic_angle;
  logic [31:0]                  half_a32, full_a32;
  logic [ANGLE_BITS-1:0]        heading_x2;
  logic signed [TW-1:0]         cordic_cos, cordic_sin;

  logic                         in_accept;
  logic                         out_load;
  logic signed [31:0]           vel_sat;
  logic signed [31:0]           pos_next;
  logic signed [31:0]           pos_cur;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_P1) && (!out_valid_q || !out_stall_i);

  assign dt_ext     = MB'($signed({1'b0, dt_q}));
  assign delta_full = mul_p >>> DELTA_SH;
  assign heading_x2 = {heading_q[ANGLE_BITS-2:0], 1'b0};

  // Bring heading angles to a 32-bit binary angle.
  if (ANGLE_BITS >= 32) begin : g_wide_angle
    assign half_a32 = heading_q[ANGLE_BITS-1 -: 32];
    assign full_a32 = heading_x2[ANGLE_BITS-1 -: 32];
  end else begin : g_narrow_angle
    assign half_a32 = {heading_q, {(32-ANGLE_BITS){1'b0}}};
    assign full_a32 = {heading_x2, {(32-ANGLE_BITS){1'b0}}};
  end

  assign cordic_start = (state_q == S_CH) || (state_q == S_CF);
  assign cordic_angle = (state_q == S_CF) ? full_a32 : half_a32;

  assign vel_sat  = udr_pkg::sat32(SW'($signed(mul_p[udr_pkg::MUL_P_W-1:30])));
  assign pos_cur  = (state_q == S_P0) ? x_q : y_q;
  assign pos_next = udr_pkg::sat32(SW'(pos_cur) +
                                   SW'($signed(mul_p[udr_pkg::MUL_P_W-1:16])));

  udr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  udr_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_angle),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  // Operand select for the shared multiplier; its product is registered and read in the following state.
  always_comb begin
    case (state_q)
      S_M0: begin
        mul_a = MA'(fwd_q);
        mul_b = MB'(speed_gain_q);
      end
      S_M1: begin
        mul_a = MA'(trn_q);
        mul_b = MB'(turn_gain_q);
      end
      S_M2: begin
        mul_a = MA'($signed(mul_p[31:0]));
        mul_b = udr_pkg::INV_4PI;
      end
      S_M3: begin
        mul_a = $signed(mul_p[61:22]);
        mul_b = dt_ext;
      end
      S_V0: begin
        mul_a = MA'(fc_q);
        mul_b = MB'(speed_q);
      end
      S_V1: begin
        mul_a = MA'(fs_q);
        mul_b = MB'(speed_q);
      end
      S_V2: begin
        mul_a = MA'(vx_q);
        mul_b = dt_ext;
      end
      S_P0, S_P1: begin
        mul_a = MA'(vy_q);
        mul_b = dt_ext;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept) state_d = S_M0;
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_CH;
      S_CH:   state_d = S_CHW;
      S_CHW:  if (cordic_done) state_d = S_CF;
      S_CF:   state_d = S_CFW;
      S_CFW:  if (cordic_done) state_d = S_V0;
      S_V0:   state_d = S_V1;
      S_V1:   state_d = S_V2;
      S_V2:   state_d = S_P0;
      S_P0:   state_d = S_P1;
      S_P1:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      speed_gain_q <= udr_pkg::SPEED_GAIN_RST;
      turn_gain_q  <= udr_pkg::TURN_GAIN_RST;
      height_q     <= udr_pkg::HEIGHT_RST;
      heading_q    <= '0;
      x_q          <= udr_pkg::X_POS_RST;
      y_q          <= udr_pkg::Y_POS_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          udr_pkg::REG_SPEED_GAIN: speed_gain_q <= $signed(cfg_data_i[15:0]);
          udr_pkg::REG_TURN_GAIN:  turn_gain_q  <= $signed(cfg_data_i[15:0]);
          udr_pkg::REG_HEIGHT:     height_q     <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (state_q == S_M4) begin
        heading_q <= heading_q + delta_full[ANGLE_BITS-1:0];
      end
      if (state_q == S_P0) begin
        x_q <= pos_next;
      end
      if (out_load) begin
        y_q <= pos_next;
      end
      // Hold the result until it is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_q <= forward_axis_i;
      trn_q <= turn_axis_i;
      dt_q  <= step_time_i;
    end
    if (state_q == S_M1) begin
      speed_q <= $signed(mul_p[31:6]);
    end
    if (state_q == S_CHW && cordic_done) begin
      qz_q <= udr_pkg::to_q14(cordic_sin);
      qw_q <= udr_pkg::to_q14(cordic_cos);
    end
    if (state_q == S_CFW && cordic_done) begin
      fc_q <= cordic_cos;
      fs_q <= cordic_sin;
    end
    if (state_q == S_V1) begin
      vx_q <= vel_sat;
    end
    if (state_q == S_V2) begin
      vy_q <= vel_sat;
    end
    if (out_load) begin
      pos_x_q  <= x_q;
      pos_y_q  <= pos_next;
      pos_z_q  <= height_q;
      quat_z_q <= qz_q;
      quat_w_q <= qw_q;
      vel_x_q  <= vx_q;
      vel_y_q  <= vy_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign quat_z_o    = quat_z_q;
  assign quat_w_o    = quat_w_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;

  `ASSERT_PROP(a_accept_starts_seq, clk_i, rst_ni, (in_accept) |=> (state_q == S_M0))
  `ASSERT_NEVER(a_cordic_done_stray, clk_i, rst_ni, cordic_done && !(state_q == S_CHW || state_q == S_CFW))
  `ASSERT_PROP(a_result_from_last_step, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_P1))
  `ASSERT_PROP(a_quat_clamped, clk_i, rst_ni, out_valid_o |-> (quat_w_o <= 16'sd16384 && quat_w_o >= -16'sd16384 && quat_z_o <= 16'sd16384 && quat_z_o >= -16'sd16384))

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 2 * udr_pkg::CORDIC_STEPS_DEF + 30;
  localparam int HEADING_SHIFT = 48 - udr_pkg::ANGLE_BITS_DEF;

  // Index 3 decodes to no register.
  localparam logic [udr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Arctangent of 2^-i, 2^32 units per turn.
  localparam longint ARCTAN_UNITS [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef enum int {
    DRIVE_MIX,
    DRIVE_SPRINT
  } drive_kind_e;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] steer;
    logic [15:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } odom_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic signed [15:0]                forward_axis_i = '0;
  logic signed [15:0]                turn_axis_i    = '0;
  logic [15:0]                       step_time_i    = '0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic signed [31:0]                pos_x_o;
  logic signed [31:0]                pos_y_o;
  logic signed [31:0]                pos_z_o;
  logic signed [15:0]                quat_z_o;
  logic signed [15:0]                quat_w_o;
  logic signed [31:0]                vel_x_o;
  logic signed [31:0]                vel_y_o;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [udr_pkg::CFG_IDX_W-1:0]     cfg_index_i    = '0;
  logic [31:0]                       cfg_data_i     = '0;

  // Predicted block state and configuration.
  logic signed [15:0] gain_speed   = udr_pkg::SPEED_GAIN_RST;
  logic signed [15:0] gain_turn    = udr_pkg::TURN_GAIN_RST;
  logic signed [31:0] height_setpt = udr_pkg::HEIGHT_RST;
  logic signed [31:0] est_x        = udr_pkg::X_POS_RST;
  logic signed [31:0] est_y        = udr_pkg::Y_POS_RST;
  logic [31:0]        est_heading  = '0;

  tick_t tick_q[$];
  odom_t odom_expect_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  unicycle_dead_reckoning_step dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return $signed(32'h8000_0000);
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] round_q14(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction

  // Cosine and sine of a 32-bit binary angle, Q2.30.
  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] shifted;
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      x, y, z, nx, ny;
    shifted = ang + 32'h2000_0000;
    quad    = shifted[31:30];
    resid   = ang - {quad, 30'b0};
    z = longint'($signed(resid));
    x = longint'(udr_pkg::CORDIC_K);
    y = 0;
    for (int i = 0; i < udr_pkg::CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ARCTAN_UNITS[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ARCTAN_UNITS[i];
      end
      x = nx;
      y = ny;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Integrate one tick and queue the pose it should report.
  function automatic void advance_odometry(logic signed [15:0] fwd,
                                           logic signed [15:0] steer, logic [15:0] dt);
    longint             speed, rate, delta, half_c, half_s, full_c, full_s;
    logic signed [31:0] vx, vy;
    odom_t              pose;
    speed = (longint'(fwd) * longint'(gain_speed)) >>> 6;
    rate  = (longint'(steer) * longint'(gain_turn) * longint'(udr_pkg::INV_4PI)) >>> 22;
    delta = (rate * longint'(dt)) >>> HEADING_SHIFT;
    est_heading = est_heading + delta[31:0];
    rotate_unit(est_heading, half_c, half_s);
    rotate_unit({est_heading[30:0], 1'b0}, full_c, full_s);
    vx = clamp32((speed * full_c) >>> 30);
    vy = clamp32((speed * full_s) >>> 30);
    est_x = clamp32(longint'(est_x) + ((longint'(vx) * longint'(dt)) >>> 16));
    est_y = clamp32(longint'(est_y) + ((longint'(vy) * longint'(dt)) >>> 16));
    pose.pos_x  = est_x;
    pose.pos_y  = est_y;
    pose.pos_z  = height_setpt;
    pose.quat_z = round_q14(half_s);
    pose.quat_w = round_q14(half_c);
    pose.vel_x  = vx;
    pose.vel_y  = vy;
    odom_expect_q.push_back(pose);
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic write_reg(input logic [udr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      udr_pkg::REG_SPEED_GAIN: gain_speed   = value[15:0];
      udr_pkg::REG_TURN_GAIN:  gain_turn    = value[15:0];
      udr_pkg::REG_HEIGHT:     height_setpt = value;
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic [15:0] fwd, input logic [15:0] steer,
                           input logic [15:0] dt);
    tick_t t;
    t.fwd   = fwd;
    t.steer = steer;
    t.dt    = dt;
    tick_q.push_back(t);
  endtask

  task automatic queue_ticks(input drive_kind_e kind, input int count);
    int          fv, sv;
    logic [15:0] dt;
    for (int n = 0; n < count; n++) begin
      if (kind == DRIVE_SPRINT) begin
        push_tick(16'($urandom_range(30000, 32767)), 16'($urandom),
                  16'($urandom_range(60000, 65535)));
      end else begin
        fv = $urandom_range(0, 32768) - 16384;
        sv = $urandom_range(0, 32768) - 16384;
        if ($urandom_range(9) == 0) fv = $urandom;
        if ($urandom_range(9) == 0) sv = $urandom;
        case ($urandom_range(3))
          0: dt = 16'($urandom_range(0, 255));
          1: dt = 16'($urandom_range(60000, 65535));
          default: dt = 16'($urandom);
        endcase
        push_tick(fv[15:0], sv[15:0], dt);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || odom_expect_q.size() != 0);
  endtask

  // Tick driver: hold a stalled request, otherwise present the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    tick_t next_tick;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      forward_axis_i <= '0;
      turn_axis_i    <= '0;
      step_time_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        advance_odometry(forward_axis_i, turn_axis_i, step_time_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_q.pop_front();
          in_valid_i     <= 1'b1;
          forward_axis_i <= next_tick.fwd;
          turn_axis_i    <= next_tick.steer;
          step_time_i    <= next_tick.dt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Pose monitor.
  always @(posedge clk_i or negedge rst_ni) begin : watch_poses
    odom_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (odom_expect_q.size() == 0) begin
          $error("pose reported with no tick outstanding");
          fail_count++;
        end else begin
          want = odom_expect_q.pop_front();
          check_field("pos_x", want.pos_x, pos_x_o);
          check_field("pos_y", want.pos_y, pos_y_o);
          check_field("pos_z", want.pos_z, pos_z_o);
          check_field("quat_z", want.quat_z, quat_z_o);
          check_field("quat_w", want.quat_w, quat_w_o);
          check_field("vel_x", want.vel_x, vel_x_o);
          check_field("vel_y", want.vel_y, vel_y_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("unicycle_dead_reckoning_step test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at reset gains: stick and time extremes, raw out-of-range sticks.
    push_tick(16'sd0, 16'sd0, 16'd0);
    push_tick(16'sd16384, 16'sd0, 16'd65535);
    push_tick(-16'sd16384, 16'sd0, 16'd65535);
    push_tick(16'sd0, 16'sd16384, 16'd65535);
    push_tick(16'sd0, -16'sd16384, 16'd65535);
    push_tick(16'sd16384, 16'sd16384, 16'd65535);
    push_tick(-16'sd16384, -16'sd16384, 16'd1);
    push_tick(16'sh7fff, 16'sd0, 16'd65535);
    push_tick(16'sh8000, 16'sd0, 16'd65535);
    push_tick(16'sd0, 16'sh7fff, 16'd65535);
    push_tick(16'sd0, 16'sh8000, 16'd65535);
    push_tick(16'sh7fff, 16'sh8000, 16'd0);
    push_tick(16'sh8000, 16'sh7fff, 16'd32768);
    push_tick(16'sd1, -16'sd1, 16'd1);
    push_tick(-16'sd1, 16'sd1, 16'd65535);
    // Spin through more than a full heading wrap.
    for (int n = 0; n < 8; n++) push_tick(16'sh4000, 16'sh7fff, 16'd65535);
    wait_drained();

    // Straight run at full positive gain to drive one axis into saturation.
    write_reg(REG_SPARE, $urandom);
    write_reg(udr_pkg::REG_SPEED_GAIN, {16'($urandom), 16'h7fff});
    write_reg(udr_pkg::REG_TURN_GAIN, 32'h0);
    send_idle_pct  = 69;
    recv_stall_pct = 0;
    queue_ticks(DRIVE_SPRINT, 190);
    wait_drained();

    // Reverse at the most negative gain, through to the other limit.
    write_reg(udr_pkg::REG_SPEED_GAIN, {16'($urandom), 16'h8000});
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    queue_ticks(DRIVE_SPRINT, 370);
    wait_drained();

    write_reg(udr_pkg::REG_SPEED_GAIN, $urandom);
    write_reg(udr_pkg::REG_TURN_GAIN, {16'($urandom), 16'h8000});
    write_reg(udr_pkg::REG_HEIGHT, 32'h8000_0000);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    queue_ticks(DRIVE_MIX, 100);
    wait_drained();

    write_reg(udr_pkg::REG_SPEED_GAIN, 32'd256);
    write_reg(udr_pkg::REG_TURN_GAIN, 32'h0000_7fff);
    write_reg(udr_pkg::REG_HEIGHT, 32'h7fff_ffff);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_ticks(DRIVE_MIX, 100);
    wait_drained();

    write_reg(udr_pkg::REG_SPEED_GAIN, 32'h0);
    write_reg(udr_pkg::REG_TURN_GAIN, $urandom);
    write_reg(udr_pkg::REG_HEIGHT, $urandom);
    send_idle_pct  = 69;
    recv_stall_pct = 69;
    queue_ticks(DRIVE_MIX, 60);
    wait_drained();

    write_reg(REG_SPARE, $urandom);
    write_reg(udr_pkg::REG_SPEED_GAIN, $urandom);
    write_reg(udr_pkg::REG_TURN_GAIN, $urandom);
    write_reg(udr_pkg::REG_HEIGHT, $urandom);
    send_idle_pct  = 21;
    recv_stall_pct = 69;
    queue_ticks(DRIVE_MIX, 100);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("unicycle_dead_reckoning_step test passed");
    end else begin
      $display("unicycle_dead_reckoning_step test failed");
    end
    $finish;
  end

endmodule
